/* hdl/slrf_pkg.sv */
// Shared constants, codes and item types for the serial line to radio framer.
package slrf_pkg;

   localparam int LINE_CAPACITY  = 59;
   localparam int FRAME_CAPACITY = 64;
   localparam int MAX_RESULTS    = 64;
   localparam int FRAME_OVERHEAD = 5;
   localparam int FRAME_LIMIT    = (FRAME_CAPACITY < MAX_RESULTS) ? FRAME_CAPACITY : MAX_RESULTS;
   localparam int QUIT_LEN       = 3;

   localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
   localparam int IDX_W = $clog2(LINE_CAPACITY);
   localparam int FL_W  = 9;

   // input item commands
   localparam logic [1:0] CMD_BYTE       = 2'd0;
   localparam logic [1:0] CMD_TX_DONE    = 2'd1;
   localparam logic [1:0] CMD_TX_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_ENTER      = 2'd3;

   // result status codes
   localparam logic [3:0] ST_NONE       = 4'd0;
   localparam logic [3:0] ST_FRAME_SENT = 4'd1;
   localparam logic [3:0] ST_QUIT       = 4'd2;
   localparam logic [3:0] ST_TOO_LONG   = 4'd3;
   localparam logic [3:0] ST_BUSY       = 4'd4;
   localparam logic [3:0] ST_OVERFLOW   = 4'd5;
   localparam logic [3:0] ST_AT_LINE    = 4'd6;
   localparam logic [3:0] ST_TX_DONE    = 4'd7;
   localparam logic [3:0] ST_TX_TIMEOUT = 4'd8;
   localparam logic [3:0] ST_ENTERED    = 4'd9;

   // register indexes
   localparam logic CSR_SRC_ADDR = 1'b0;
   localparam logic CSR_DST_ADDR = 1'b1;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;

   // what the output register loads
   localparam logic [2:0] PUSH_NONE   = 3'd0;
   localparam logic [2:0] PUSH_STATUS = 3'd1;
   localparam logic [2:0] PUSH_HDR    = 3'd2;
   localparam logic [2:0] PUSH_LINE   = 3'd3;
   localparam logic [2:0] PUSH_SUM    = 3'd4;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       is_frame_byte;
      logic [7:0] frame_byte;
      logic       last_of_run;
      logic [3:0] status_code;
   } rsp_type;

   typedef struct packed {
      logic       latch_item;
      logic       store_byte;
      logic [2:0] push_sel;
      logic [3:0] status_code;
      logic       clr_len;
      logic       set_trans;
      logic       clr_trans;
      logic       set_busy;
      logic       clr_busy;
      logic       clr_idx;
      logic       inc_idx;
      logic       clr_sum;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       is_eol;
      logic       line_empty;
      logic       line_full;
      logic       is_quit;
      logic       too_long;
      logic       transparent;
      logic       busy;
      logic       hdr_last;
      logic       line_last;
      logic       out_free;
   } dp_status_type;

endpackage

/* hdl/slrf_dp.sv */
// Datapath: line store, line state flags, frame checksum and output register.
module slrf_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  slrf_pkg::req_type      req_item,
   input  logic                   csr_valid,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data,
   input  slrf_pkg::ctrl_cmd_type cmd,
   output slrf_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slrf_pkg::rsp_type      rsp_item
);
   import slrf_pkg::*;

   logic [7:0]       line_mem [LINE_CAPACITY];
   logic [7:0]       rd_data_ff;
   req_type          item_ff;
   logic [15:0]      src_addr_ff;
   logic [15:0]      dst_addr_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             all_plus_ff, all_plus_in;
   logic             trans_ff, trans_in;
   logic             busy_ff, busy_in;
   logic             out_valid_ff;
   rsp_type          out_ff, out_in;
   logic [7:0]       hdr_byte;
   logic             ch_plus;

   assign ch_plus = (item_ff.data_byte == CHAR_PLUS);

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    hdr_byte = src_addr_ff[15:8];
         2'd1:    hdr_byte = src_addr_ff[7:0];
         2'd2:    hdr_byte = dst_addr_ff[15:8];
         default: hdr_byte = dst_addr_ff[7:0];
      endcase
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.store_byte) len_in = len_ff + LEN_W'(1);
      if (cmd.clr_len) len_in = '0;

      all_plus_in = all_plus_ff;
      if (cmd.store_byte) all_plus_in = (len_ff == '0) ? ch_plus : (all_plus_ff && ch_plus);

      idx_in = idx_ff;
      if (cmd.inc_idx) idx_in = idx_ff + IDX_W'(1);
      if (cmd.clr_idx) idx_in = '0;

      sum_in = sum_ff;
      if (cmd.push_sel == PUSH_HDR) sum_in = sum_ff + hdr_byte;
      if (cmd.push_sel == PUSH_LINE) sum_in = sum_ff + rd_data_ff;
      if (cmd.clr_sum) sum_in = '0;

      trans_in = trans_ff;
      if (cmd.set_trans) trans_in = 1'b1;
      if (cmd.clr_trans) trans_in = 1'b0;

      busy_in = busy_ff;
      if (cmd.set_busy) busy_in = 1'b1;
      if (cmd.clr_busy) busy_in = 1'b0;

      case (cmd.push_sel)
         PUSH_HDR:  out_in = '{is_frame_byte: 1'b1, frame_byte: hdr_byte,
                              last_of_run: 1'b0, status_code: ST_NONE};
         PUSH_LINE: out_in = '{is_frame_byte: 1'b1, frame_byte: rd_data_ff,
                              last_of_run: 1'b0, status_code: ST_NONE};
         PUSH_SUM:  out_in = '{is_frame_byte: 1'b1, frame_byte: 8'(~sum_ff + 8'd1),
                              last_of_run: 1'b1, status_code: ST_FRAME_SENT};
         default:   out_in = '{is_frame_byte: 1'b0, frame_byte: 8'd0,
                              last_of_run: 1'b1, status_code: cmd.status_code};
      endcase
   end

   // line store: one write port, registered read at the frame index
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         line_mem[len_ff[IDX_W-1:0]] <= item_ff.data_byte;
      end
      rd_data_ff <= line_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) item_ff <= req_item;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      all_plus_ff <= all_plus_in;
      if (cmd.push_sel != PUSH_NONE) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         trans_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         src_addr_ff  <= '0;
         dst_addr_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         trans_ff <= trans_in;
         busy_ff  <= busy_in;
         if (cmd.push_sel != PUSH_NONE) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_index == CSR_SRC_ADDR) src_addr_ff <= csr_data;
         if (csr_valid && csr_index == CSR_DST_ADDR) dst_addr_ff <= csr_data;
      end
   end

   assign status.command     = item_ff.command;
   assign status.is_eol      = (item_ff.data_byte == CHAR_CR) || (item_ff.data_byte == CHAR_LF);
   assign status.line_empty  = (len_ff == '0);
   assign status.line_full   = (len_ff == LEN_W'(LINE_CAPACITY));
   assign status.is_quit     = all_plus_ff && (len_ff == LEN_W'(QUIT_LEN));
   assign status.too_long    = (FL_W'(len_ff) + FL_W'(FRAME_OVERHEAD)) > FL_W'(FRAME_LIMIT);
   assign status.transparent = trans_ff;
   assign status.busy        = busy_ff;
   assign status.hdr_last    = (idx_ff[1:0] == 2'd3);
   assign status.line_last   = ((LEN_W+1)'(idx_ff) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_ff);
   assign status.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

/* hdl/slrf_ctrl.sv */
// Controller: decodes each item and sequences status and frame byte emission.
module slrf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  slrf_pkg::dp_status_type status,
   output slrf_pkg::ctrl_cmd_type  cmd
);
   import slrf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_HDR    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_BYTE   = 3'd4;
   localparam logic [2:0] S_SUM    = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      logic       send_status;
      logic [3:0] code;
      send_status = 1'b0;
      code        = ST_NONE;
      cmd         = '0;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.command != CMD_BYTE) begin
               send_status = 1'b1;
               case (status.command)
                  CMD_TX_DONE:    code = ST_TX_DONE;
                  CMD_TX_TIMEOUT: code = ST_TX_TIMEOUT;
                  default:        code = ST_ENTERED;
               endcase
               if (status.out_free) begin
                  cmd.clr_busy  = 1'b1;
                  cmd.set_trans = (status.command == CMD_ENTER);
               end
            end else if (!status.is_eol) begin
               if (!status.line_full) begin
                  cmd.store_byte = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  send_status = 1'b1;
                  code        = ST_OVERFLOW;
               end
            end else if (status.line_empty) begin
               state_in = S_IDLE;
            end else if (!status.transparent) begin
               send_status = 1'b1;
               code        = ST_AT_LINE;
            end else if (status.is_quit) begin
               send_status = 1'b1;
               code        = ST_QUIT;
               cmd.clr_trans = status.out_free;
            end else if (status.too_long) begin
               send_status = 1'b1;
               code        = ST_TOO_LONG;
            end else if (status.busy) begin
               send_status = 1'b1;
               code        = ST_BUSY;
            end else begin
               cmd.clr_idx = 1'b1;
               cmd.clr_sum = 1'b1;
               state_in    = S_HDR;
            end
            if (send_status && status.out_free) begin
               cmd.push_sel    = PUSH_STATUS;
               cmd.status_code = code;
               // every status on a byte item ends the line
               cmd.clr_len     = (status.command == CMD_BYTE);
               state_in        = S_IDLE;
            end
         end
         S_HDR: begin
            if (status.out_free) begin
               cmd.push_sel = PUSH_HDR;
               cmd.inc_idx  = 1'b1;
               if (status.hdr_last) begin
                  cmd.clr_idx = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_BYTE;
         end
         S_BYTE: begin
            if (status.out_free) begin
               cmd.push_sel = PUSH_LINE;
               if (status.line_last) begin
                  state_in = S_SUM;
               end else begin
                  cmd.inc_idx = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_SUM: begin
            if (status.out_free) begin
               cmd.push_sel = PUSH_SUM;
               cmd.set_busy = 1'b1;
               cmd.clr_len  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* hdl/serial_line_to_radio_framer.sv */
// Top level of the serial line to radio framer.
// Takes console bytes and control events one item at a time: an item is latched while idle
// and decoded in the next cycle; a plain byte, an empty line end or any status-only result
// then returns to idle when the output is free. A finished line in transparent mode is sent
// as a frame of source address, destination address (both big-endian), the line bytes and a
// checksum, the two's complement of the sum of header and line bytes: four header bytes, then
// a read state and a byte state per line byte (registered read of the line store), then the
// checksum byte. A result waiting in the output register does not block acceptance of the
// next item; a stalled consumer holds the sequencer. Configuration writes are always taken.
module serial_line_to_radio_framer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slrf_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slrf_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);
   import slrf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   slrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slrf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   a_sent_is_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status_code == ST_FRAME_SENT)
         |-> (rsp_item.is_frame_byte && rsp_item.last_of_run))
      else $error("frame sent status not on the checksum item");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.is_frame_byte) |-> rsp_item.last_of_run)
      else $error("status-only item not marked last");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item taken during decode");

   a_frame_byte_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_frame_byte && !rsp_item.last_of_run)
         |-> (rsp_item.status_code == ST_NONE))
      else $error("inner frame byte carries a status");

endmodule
